[rtl/core/cbpg_pkg.sv]
package cbpg_pkg;

   // curve resolution
   localparam int NUM_POINTS = 32;
   localparam int COORD_W    = 16;
   localparam int IDX_W      = $clog2(NUM_POINTS);
   localparam int NUM_PTS    = 8;

   // parameter step in unsigned q0.16, rounded to nearest
   localparam longint STEP_Q16 = (65536 + (NUM_POINTS - 1) / 2) / (NUM_POINTS - 1);
   localparam longint T_MASK   = 64'h1_FFFF;
   localparam longint ONE_Q16  = 65536;

   // bernstein weights carry 48 fraction bits, magnitude below 2^49
   localparam int FRAC_W = 48;
   localparam int WGT_W  = 50;
   localparam int WLO_W  = 25;
   localparam int WHI_W  = WGT_W - WLO_W;
   localparam int PLO_W  = WLO_W + 1 + COORD_W;
   localparam int PHI_W  = WHI_W + COORD_W;
   localparam int TERM_W = WGT_W + COORD_W;
   localparam int PAIR_W = TERM_W + 1;
   localparam int SUM_W  = TERM_W + 2;
   localparam int QUO_W  = SUM_W - FRAC_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

   typedef logic signed [COORD_W-1:0] coord_type;
   // order: start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
   typedef logic [NUM_PTS-1:0][COORD_W-1:0] ctrl_pts_type;
   typedef logic [3:0][WGT_W-1:0] weight_set_type;
   typedef logic [NUM_POINTS-1:0][3:0][WGT_W-1:0] weight_tab_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             last;
      ctrl_pts_type     pts;
   } issue_type;

   typedef struct packed {
      logic                        last;
      logic [1:0][3:0][TERM_W-1:0] terms;
   } term_set_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // weights u^3, 3tu^2, 3t^2u, t^3 for every point index
   function automatic weight_tab_type build_weight_tab();
      weight_tab_type tab;
      longint         t;
      longint         u;
      tab = '0;
      for (int i = 0; i < NUM_POINTS; i++) begin
         t = (longint'(i) * STEP_Q16) & T_MASK;
         u = ONE_Q16 - t;
         tab[i][0] = WGT_W'(u * u * u);
         tab[i][1] = WGT_W'(3 * t * u * u);
         tab[i][2] = WGT_W'(3 * t * t * u);
         tab[i][3] = WGT_W'(t * t * t);
      end
      return tab;
   endfunction

   localparam weight_tab_type WEIGHT_TAB = build_weight_tab();

endpackage

[rtl/core/cbpg_ifs.sv]
interface cbpg_req_if;
   logic                valid;
   logic                ready;
   cbpg_pkg::coord_type start_x;
   cbpg_pkg::coord_type start_y;
   cbpg_pkg::coord_type ctrl1_x;
   cbpg_pkg::coord_type ctrl1_y;
   cbpg_pkg::coord_type ctrl2_x;
   cbpg_pkg::coord_type ctrl2_y;
   cbpg_pkg::coord_type end_x;
   cbpg_pkg::coord_type end_y;

   modport source (
      output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
      output ready
   );
endinterface

interface cbpg_rsp_if;
   logic                valid;
   logic                ready;
   cbpg_pkg::coord_type point_x;
   cbpg_pkg::coord_type point_y;
   logic                last_point;

   modport source (
      output valid, point_x, point_y, last_point,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, last_point,
      output ready
   );
endinterface

[rtl/core/cbpg_sequencer.sv]
module cbpg_sequencer (
   input  logic                clock,
   input  logic                reset,
   cbpg_req_if.sink            req_chan,
   output logic                issue_valid,
   input  logic                issue_ready,
   output cbpg_pkg::issue_type issue
);
   import cbpg_pkg::*;

   seq_state_type    state_ff, state_in;
   ctrl_pts_type     pts_ff, pts_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             take_req;
   logic             fire;
   logic             at_last;

   assign take_req = req_chan.valid && req_chan.ready;
   assign fire     = issue_valid && issue_ready;
   assign at_last  = (idx_ff == LAST_IDX);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (take_req) state_in = SEQ_RUN;
         end
         SEQ_RUN: begin
            if (fire && at_last && !take_req) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      issue_valid    = 1'b0;
      req_chan.ready = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_chan.ready = 1'b1;
         end
         SEQ_RUN: begin
            issue_valid    = 1'b1;
            req_chan.ready = issue_ready && at_last;
         end
         default: begin
            issue_valid    = 1'b0;
            req_chan.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      pts_in = pts_ff;
      idx_in = idx_ff;
      if (take_req) begin
         pts_in = {req_chan.end_y, req_chan.end_x, req_chan.ctrl2_y, req_chan.ctrl2_x,
                   req_chan.ctrl1_y, req_chan.ctrl1_x, req_chan.start_y, req_chan.start_x};
         idx_in = '0;
      end else if (fire && !at_last) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pts_ff <= pts_in;
   end

   assign issue.idx  = idx_ff;
   assign issue.last = at_last;
   assign issue.pts  = pts_ff;

endmodule

[rtl/core/cbpg_product.sv]
module cbpg_product (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cbpg_pkg::issue_type    issue,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cbpg_pkg::term_set_type terms
);
   import cbpg_pkg::*;

   // stage 1: weight lookup
   logic                        v1_ff, v1_in;
   weight_set_type              w1_ff;
   ctrl_pts_type                pts1_ff;
   logic                        last1_ff;
   // stage 2: split partial products
   logic                        v2_ff, v2_in;
   logic [1:0][3:0][PLO_W-1:0]  lo2_ff, lo2_in;
   logic [1:0][3:0][PHI_W-1:0]  hi2_ff, hi2_in;
   logic                        last2_ff;
   // stage 3: full terms
   logic                        v3_ff, v3_in;
   logic [1:0][3:0][TERM_W-1:0] term3_ff, term3_in;
   logic                        last3_ff;

   logic                        rdy1, rdy2, rdy3;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign v1_in = rdy1 ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   // low weight half unsigned, high half signed
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         for (int k = 0; k < 4; k++) begin
            lo2_in[a][k] = $signed({1'b0, w1_ff[k][WLO_W-1:0]}) * $signed(pts1_ff[2*k+a]);
            hi2_in[a][k] = $signed(w1_ff[k][WGT_W-1:WLO_W]) * $signed(pts1_ff[2*k+a]);
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         for (int k = 0; k < 4; k++) begin
            term3_in[a][k] = $signed({hi2_ff[a][k], {WLO_W{1'b0}}})
                           + $signed(TERM_W'($signed(lo2_ff[a][k])));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         w1_ff    <= WEIGHT_TAB[issue.idx];
         pts1_ff  <= issue.pts;
         last1_ff <= issue.last;
      end
      if (rdy2) begin
         lo2_ff   <= lo2_in;
         hi2_ff   <= hi2_in;
         last2_ff <= last1_ff;
      end
      if (rdy3) begin
         term3_ff <= term3_in;
         last3_ff <= last2_ff;
      end
   end

   assign out_valid   = v3_ff;
   assign terms.last  = last3_ff;
   assign terms.terms = term3_ff;

endmodule

[rtl/core/cbpg_accum.sv]
module cbpg_accum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cbpg_pkg::term_set_type terms,
   cbpg_rsp_if.source             rsp_chan
);
   import cbpg_pkg::*;

   localparam logic [SUM_W-1:0] TRUNC_BIAS = {{(SUM_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};
   localparam int SAT_W = QUO_W - COORD_W + 1;

   logic                        v4_ff, v4_in;
   logic [1:0][1:0][PAIR_W-1:0] pair4_ff, pair4_in;
   logic                        last4_ff;
   logic                        v5_ff, v5_in;
   logic [1:0][SUM_W-1:0]       sum5_ff, sum5_in;
   logic                        last5_ff;
   logic                        v6_ff, v6_in;
   logic [1:0][COORD_W-1:0]     pt6_ff, pt6_in;
   logic                        last6_ff;

   logic                        rdy4, rdy5, rdy6;

   // truncate toward zero, then clamp to the coordinate range
   function automatic logic [COORD_W-1:0] trunc_sat(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] biased;
      logic [QUO_W-1:0] quo;
      logic [SAT_W-1:0] top;
      biased = s + (s[SUM_W-1] ? TRUNC_BIAS : '0);
      quo    = biased[SUM_W-1:FRAC_W];
      top    = quo[QUO_W-1:COORD_W-1];
      if ((top == '0) || (top == '1)) begin
         return quo[COORD_W-1:0];
      end else if (quo[QUO_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   assign rdy6     = !v6_ff || rsp_chan.ready;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   assign v4_in = rdy4 ? in_valid : v4_ff;
   assign v5_in = rdy5 ? v4_ff : v5_ff;
   assign v6_in = rdy6 ? v5_ff : v6_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         for (int h = 0; h < 2; h++) begin
            pair4_in[a][h] = $signed(PAIR_W'($signed(terms.terms[a][2*h])))
                           + $signed(PAIR_W'($signed(terms.terms[a][2*h+1])));
         end
         sum5_in[a] = $signed(SUM_W'($signed(pair4_ff[a][0])))
                    + $signed(SUM_W'($signed(pair4_ff[a][1])));
         pt6_in[a]  = trunc_sat(sum5_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         pair4_ff <= pair4_in;
         last4_ff <= terms.last;
      end
      if (rdy5) begin
         sum5_ff  <= sum5_in;
         last5_ff <= last4_ff;
      end
      if (rdy6) begin
         pt6_ff   <= pt6_in;
         last6_ff <= last5_ff;
      end
   end

   assign rsp_chan.valid      = v6_ff;
   assign rsp_chan.point_x    = pt6_ff[0];
   assign rsp_chan.point_y    = pt6_ff[1];
   assign rsp_chan.last_point = last6_ff;

endmodule

[rtl/core/cubic_bezier_point_generator.sv]
// cubic bezier point generator: each request carries the four control points of a
// cubic curve and yields NUM_POINTS (package constant, 32 by default) points, the
// first being the start point and point i the curve at t = i * step, step being
// 1/(NUM_POINTS-1) rounded to q0.16; the last point of a curve has last_point set.
// coordinates are computed exactly and truncated toward zero, then clamped to the
// 16-bit range. a request holds the point sequencer until its last point issues,
// one point per cycle while the product pipe is ready, and the next curve is taken
// with no gap; a curve's first point passes the lookup, partial product, term,
// pair sum, sum and output registers. rsp backpressure stalls the stages behind it,
// and empty stages fill while the output waits, so no point is dropped or repeated.
module cubic_bezier_point_generator (
   input  logic       clock,
   input  logic       reset,
   cbpg_req_if.sink   req_chan,
   cbpg_rsp_if.source rsp_chan
);
   import cbpg_pkg::*;

   // sequencer to product pipe
   logic         issue_valid;
   logic         issue_ready;
   issue_type    issue;
   // product pipe to accumulate pipe
   logic         term_valid;
   logic         term_ready;
   term_set_type terms;

   // holds the curve and steps the point index
   cbpg_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .issue_valid (issue_valid),
      .issue_ready (issue_ready),
      .issue       (issue)
   );

   // weight table lookup, split multiplies, term assembly
   cbpg_product u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue_valid),
      .in_ready  (issue_ready),
      .issue     (issue),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .terms     (terms)
   );

   // adder tree, truncation, saturation, output register
   cbpg_accum u_acc (
      .clock    (clock),
      .reset    (reset),
      .in_valid (term_valid),
      .in_ready (term_ready),
      .terms    (terms),
      .rsp_chan (rsp_chan)
   );

endmodule

[rtl/core/cbpg_checker.sv]
module cbpg_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input cbpg_pkg::coord_type point_x,
   input cbpg_pkg::coord_type point_y,
   input logic                last_point
);
   import cbpg_pkg::*;

   // a point waiting at the output stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // and its payload holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(point_x) && $stable(point_y) && $stable(last_point))
      else $error("rsp payload changed while stalled");

   // pipeline empties on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a curve holds the sequencer, so requests are never accepted back to back
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(req_valid && req_ready))
      else $error("two requests accepted in consecutive cycles");

endmodule

bind cubic_bezier_point_generator cbpg_checker u_cbpg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .point_x    (rsp_chan.point_x),
   .point_y    (rsp_chan.point_y),
   .last_point (rsp_chan.last_point)
);
